// ===== hw/rtl/dfb_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dfb_pkg
// Shared types and constants of the page framebuffer draw unit: request
// codes, draw modes, the queued command and the result record.
// ============================================================================
package dfb_pkg;

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;
    localparam int CMD_DEPTH         = 2;
    localparam int RES_DEPTH         = 2;

    localparam logic [2:0] REQ_PIXEL = 3'd0;
    localparam logic [2:0] REQ_HLINE = 3'd1;
    localparam logic [2:0] REQ_VLINE = 3'd2;
    localparam logic [2:0] REQ_RECT  = 3'd3;
    localparam logic [2:0] REQ_FILL  = 3'd4;
    localparam logic [2:0] REQ_CLEAR = 3'd5;
    localparam logic [2:0] REQ_READ  = 3'd6;

    localparam logic [1:0] MODE_CLR = 2'd0;
    localparam logic [1:0] MODE_SET = 2'd1;
    localparam logic [1:0] MODE_XOR = 2'd2;

    typedef struct packed {
        logic [2:0] req;
        logic [7:0] x;
        logic [7:0] y;
        logic [8:0] x_end;
        logic [8:0] y_end;
        logic [7:0] rows;
        logic [1:0] mode;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] done_type;
    } t_res;

endpackage

// ===== hw/rtl/mono_page_framebuffer_draw_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mono_page_framebuffer_draw_unit
// Page-organized monochrome framebuffer with pixel, line, rectangle, fill,
// clear and byte-read requests; one result transaction per request.
// ============================================================================
// Usage:
//   Requests enter through a queue port: a transaction is taken at a clock
//   edge with i_push high and o_full low. Results leave through a queue
//   port: the oldest result is shown while o_empty is low and is taken at
//   an edge with i_pop high.
//   A two-entry command queue separates intake from the drawing engine, and
//   a two-entry result queue separates the engine from the receiver, so
//   requests keep being taken while a result waits.
//   Each drawing request is split into line segments; each segment is set
//   up, then each of its pixels is read and written back, a read-modify-write
//   of the frame store, and the result is queued last. A byte read fetches
//   one byte of the frame store and queues it. A clear writes zero to every
//   byte of the frame store. The engine takes the next request the cycle after
//   a result is queued and never before, so it works on one request at a time.
//   Reset: queues empty, then a clearing pass over the whole frame store
//   during which o_full stays high.
//   A stalled receiver fills the result queue, then the engine holds, then
//   the command queue fills and o_full rises; nothing is dropped.
// ============================================================================
module mono_page_framebuffer_draw_unit
    import dfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_x_pos,
    input  logic [7:0] i_y_pos,
    input  logic [7:0] i_width,
    input  logic [7:0] i_height,
    input  logic [1:0] i_draw_mode,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_read_data,
    output logic [2:0] o_done_type
);

    t_cmd                    cmd;
    logic                    cmd_empty;
    logic                    cmd_pop;
    logic                    init;
    logic                    res_push;
    t_res                    res_in;
    logic                    res_full;
    logic [$bits(t_res)-1:0] res_data;
    t_res                    res_out;

    dfb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_hold      (init),
        .i_req_type  (i_req_type),
        .i_x_pos     (i_x_pos),
        .i_y_pos     (i_y_pos),
        .i_width     (i_width),
        .i_height    (i_height),
        .i_draw_mode (i_draw_mode),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty),
        .i_cmd_pop   (cmd_pop)
    );

    dfb_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_init      (init),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    dfb_fifo #(
        .DW    ($bits(t_res)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (res_data),
        .o_empty (o_empty)
    );

    assign res_out     = t_res'(res_data);
    assign o_read_data = res_out.read_data;
    assign o_done_type = res_out.done_type;

endmodule

// ===== hw/rtl/dfb_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dfb_fifo
// Small first-in first-out queue with registered storage and full/empty flags.
// ============================================================================
module dfb_fifo
    import dfb_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = CMD_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_data [DEPTH];
    logic [IW-1:0] r_wp;
    logic [IW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_data[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == IW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == IW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/dfb_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dfb_front
// Request intake: classifies each request (end coordinates, effective draw
// mode) and queues it as a command for the drawing engine.
// ============================================================================
module dfb_front
    import dfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic       i_hold,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_x_pos,
    input  logic [7:0] i_y_pos,
    input  logic [7:0] i_width,
    input  logic [7:0] i_height,
    input  logic [1:0] i_draw_mode,
    output t_cmd       o_cmd,
    output logic       o_cmd_empty,
    input  logic       i_cmd_pop
);

    t_cmd                   cmd;
    logic                   q_full;
    logic [$bits(t_cmd)-1:0] q_data;

    always_comb begin
        cmd.req   = i_req_type;
        cmd.x     = i_x_pos;
        cmd.y     = i_y_pos;
        cmd.x_end = {1'b0, i_x_pos} + {1'b0, i_width};
        cmd.y_end = {1'b0, i_y_pos} + {1'b0, i_height};
        cmd.rows  = i_height;
        if (i_req_type == REQ_PIXEL) begin
            cmd.mode = i_draw_mode;
        end else begin
            cmd.mode = (i_draw_mode != MODE_CLR) ? MODE_SET : MODE_CLR;
        end
    end

    assign o_full = q_full || i_hold;
    assign o_cmd  = t_cmd'(q_data);

    dfb_fifo #(
        .DW    ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_data  (cmd),
        .o_full  (q_full),
        .i_pop   (i_cmd_pop),
        .o_data  (q_data),
        .o_empty (o_cmd_empty)
    );

endmodule

// ===== hw/rtl/dfb_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dfb_back
// Drawing engine: owns, clears and reads back the frame store; breaks drawing
// commands into clipped segments, walked pixel by pixel by read-modify-write.
// ============================================================================
module dfb_back
    import dfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_empty,
    output logic o_cmd_pop,
    output logic o_init,
    output logic o_res_push,
    output t_res o_res,
    input  logic i_res_full
);

    localparam int FB_PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int FB_BYTES = FB_PAGES * SCREEN_WIDTH;
    localparam int AW       = $clog2(FB_BYTES);
    localparam logic [8:0] XLIM = 9'(SCREEN_WIDTH);
    localparam logic [8:0] YLIM = 9'(SCREEN_HEIGHT);
    localparam logic [8:0] XMAX = 9'(SCREEN_WIDTH - 1);
    localparam logic [8:0] YMAX = 9'(SCREEN_HEIGHT - 1);

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_SEG, ST_RD, ST_WR, ST_CLR, ST_RB, ST_RBW, ST_DONE
    } t_state;

    t_state         r_state;
    t_cmd           r_cmd;
    logic [1:0]     r_seg;
    logic [7:0]     r_row;
    logic           r_vert;
    logic [8:0]     r_cur;
    logic [8:0]     r_end;
    logic [8:0]     r_fix;
    logic [AW-1:0]  r_addr;
    logic [2:0]     r_bit;
    logic [AW-1:0]  r_sweep;
    logic           r_rb_ok;
    logic [7:0]     r_res_data;
    logic [7:0]     r_rdata;
    logic [7:0]     r_mem [FB_BYTES];

    logic           seg_vert;
    logic [8:0]     seg_start;
    logic [8:0]     seg_stop;
    logic [8:0]     seg_fix;
    logic [8:0]     seg_stop_c;
    logic           seg_empty;
    logic           seg_last;
    logic [7:0]     pix_col;
    logic [7:0]     pix_row;
    logic [AW-1:0]  pix_addr;
    logic [AW-1:0]  rb_addr;
    logic           rb_ok;
    logic [7:0]     bit_mask;
    logic [7:0]     new_byte;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic [AW-1:0]  mem_raddr;
    logic           sweep_last;

    always_comb begin
        seg_vert  = 1'b0;
        seg_start = {1'b0, r_cmd.x};
        seg_stop  = r_cmd.x_end;
        seg_fix   = {1'b0, r_cmd.y};
        seg_last  = 1'b1;
        unique case (r_cmd.req) inside
            REQ_PIXEL: begin
                seg_stop = {1'b0, r_cmd.x};
            end
            REQ_VLINE: begin
                seg_vert  = 1'b1;
                seg_start = {1'b0, r_cmd.y};
                seg_stop  = r_cmd.y_end;
                seg_fix   = {1'b0, r_cmd.x};
            end
            REQ_RECT: begin
                seg_last = (r_seg == 2'd3);
                unique case (r_seg)
                    2'd1: begin
                        seg_vert  = 1'b1;
                        seg_start = {1'b0, r_cmd.y};
                        seg_stop  = r_cmd.y_end;
                        seg_fix   = {1'b0, r_cmd.x};
                    end
                    2'd2: begin
                        seg_fix = r_cmd.y_end;
                    end
                    2'd3: begin
                        seg_vert  = 1'b1;
                        seg_start = {1'b0, r_cmd.y};
                        seg_stop  = r_cmd.y_end;
                        seg_fix   = r_cmd.x_end;
                    end
                    default: begin
                    end
                endcase
            end
            REQ_FILL: begin
                seg_fix  = {1'b0, r_cmd.y} + {1'b0, r_row};
                seg_last = (r_row == r_cmd.rows - 8'd1);
            end
            default: begin
            end
        endcase
        if (seg_vert) begin
            seg_stop_c = (seg_stop > YMAX) ? YMAX : seg_stop;
            seg_empty  = (seg_fix >= XLIM);
        end else begin
            seg_stop_c = (seg_stop > XMAX) ? XMAX : seg_stop;
            seg_empty  = (seg_fix >= YLIM);
        end
        seg_empty = seg_empty || (seg_start > seg_stop_c);
    end

    always_comb begin
        pix_col  = r_vert ? r_fix[7:0] : r_cur[7:0];
        pix_row  = r_vert ? r_cur[7:0] : r_fix[7:0];
        pix_addr = AW'(int'(pix_row[7:3]) * SCREEN_WIDTH + int'(pix_col));
        rb_addr  = AW'(int'(r_cmd.y[7:3]) * SCREEN_WIDTH + int'(r_cmd.x));
        rb_ok    = ({1'b0, r_cmd.x} < XLIM) && ({1'b0, r_cmd.y} < YLIM);
        bit_mask = 8'd1 << r_bit;
        case (r_cmd.mode)
            MODE_SET: new_byte = r_rdata | bit_mask;
            MODE_XOR: new_byte = r_rdata ^ bit_mask;
            default:  new_byte = r_rdata & ~bit_mask;
        endcase
        sweep_last = (r_sweep == AW'(FB_BYTES - 1));
        mem_we     = (r_state == ST_INIT) || (r_state == ST_CLR) || (r_state == ST_WR);
        mem_waddr  = (r_state == ST_WR) ? r_addr : r_sweep;
        mem_wdata  = (r_state == ST_WR) ? new_byte : 8'd0;
        mem_raddr  = (r_state == ST_RB) ? rb_addr : pix_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    assign o_cmd_pop       = (r_state == ST_IDLE) && !i_cmd_empty;
    assign o_init          = (r_state == ST_INIT);
    assign o_res_push      = (r_state == ST_DONE) && !i_res_full;
    assign o_res.read_data = r_res_data;
    assign o_res.done_type = r_cmd.req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_sweep <= '0;
        end else begin
            unique case (r_state)
                ST_INIT: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (sweep_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd      <= i_cmd;
                        r_seg      <= '0;
                        r_row      <= '0;
                        r_sweep    <= '0;
                        r_res_data <= '0;
                        unique case (i_cmd.req) inside
                            REQ_PIXEL, REQ_HLINE, REQ_VLINE, REQ_RECT: r_state <= ST_SEG;
                            REQ_FILL: begin
                                r_state <= (i_cmd.rows == '0) ? ST_DONE : ST_SEG;
                            end
                            REQ_CLEAR: r_state <= ST_CLR;
                            REQ_READ:  r_state <= ST_RB;
                            default:   r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_SEG: begin
                    r_vert <= seg_vert;
                    r_cur  <= seg_start;
                    r_end  <= seg_stop_c;
                    r_fix  <= seg_fix;
                    if (!seg_empty) begin
                        r_state <= ST_RD;
                    end else if (seg_last) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_seg <= r_seg + 1'b1;
                        r_row <= r_row + 1'b1;
                    end
                end
                ST_RD: begin
                    r_addr  <= pix_addr;
                    r_bit   <= pix_row[2:0];
                    r_state <= ST_WR;
                end
                ST_WR: begin
                    if (r_cur == r_end) begin
                        if (seg_last) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_seg   <= r_seg + 1'b1;
                            r_row   <= r_row + 1'b1;
                            r_state <= ST_SEG;
                        end
                    end else begin
                        r_cur   <= r_cur + 1'b1;
                        r_state <= ST_RD;
                    end
                end
                ST_CLR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (sweep_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_RB: begin
                    r_rb_ok <= rb_ok;
                    r_state <= ST_RBW;
                end
                ST_RBW: begin
                    r_res_data <= r_rb_ok ? r_rdata : 8'd0;
                    r_state    <= ST_DONE;
                end
                ST_DONE: begin
                    if (!i_res_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/dfb_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dfb_checker
// Port-level checks of the draw unit: reset behavior, result stability and
// the zero read data of non-read results.
// ============================================================================
module dfb_checker
    import dfb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_full,
    input logic       o_empty,
    input logic       i_pop,
    input logic [7:0] o_read_data,
    input logic [2:0] o_done_type
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> o_full)
        else $error("request port open during clearing pass");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_read_data) && $stable(o_done_type))
        else $error("waiting result changed before pop");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && (o_done_type != REQ_READ) |-> o_read_data == 8'd0)
        else $error("nonzero read data on non-read result");

endmodule

bind mono_page_framebuffer_draw_unit dfb_checker u_dfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_full      (o_full),
    .o_empty     (o_empty),
    .i_pop       (i_pop),
    .o_read_data (o_read_data),
    .o_done_type (o_done_type)
);
